>>> rtl/core/wire_elbow_snap_top_assert.svh
// Assertion macros for the wire elbow snap block.
// Both macros sample on clk; the first also ignores cycles in reset.
`ifndef WIRE_ELBOW_SNAP_TOP_ASSERT_SVH
`define WIRE_ELBOW_SNAP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define WES_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wire_elbow_snap: pipeline check failed");
`define WES_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("wire_elbow_snap: reset check failed");
`else
`define WES_ASSERT(label, prop)
`define WES_ASSERT_RST(label, prop)
`endif
`endif

>>> rtl/core/wes_pkg.sv
package wes_pkg;

  // bend styles, also the index into the candidate arrays
  typedef enum logic [1:0] {
    STYLE_CORNER_A   = 2'd0,
    STYLE_DIAG_START = 2'd1,
    STYLE_CORNER_B   = 2'd2,
    STYLE_DIAG_END   = 2'd3
  } style_t;

  // request commands
  typedef enum logic {
    CMD_PLACE = 1'b0,
    CMD_SNAP  = 1'b1
  } cmd_t;

  localparam int NUM_STYLES = 4;

endpackage

>>> rtl/core/wes_cand.sv
// Two stages: axis distances, then the four candidate bend points.
module wes_cand import wes_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cmd_t                              in_cmd,
  input  style_t                            in_style,
  input  logic signed [COORD_BITS-1:0]      in_sx,
  input  logic signed [COORD_BITS-1:0]      in_sy,
  input  logic signed [COORD_BITS-1:0]      in_ex,
  input  logic signed [COORD_BITS-1:0]      in_ey,
  input  logic signed [COORD_BITS-1:0]      in_tx,
  input  logic signed [COORD_BITS-1:0]      in_ty,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cmd_t                              out_cmd,
  output style_t                            out_style,
  output logic signed [COORD_BITS-1:0]      out_tx,
  output logic signed [COORD_BITS-1:0]      out_ty,
  output logic [NUM_STYLES-1:0][COORD_BITS-1:0] out_cx,
  output logic [NUM_STYLES-1:0][COORD_BITS-1:0] out_cy
);

  localparam int C = COORD_BITS;

  // stage A registers
  logic                 a_valid;
  cmd_t                 a_cmd;
  style_t               a_style;
  logic signed [C-1:0]  a_sx, a_sy, a_ex, a_ey, a_tx, a_ty;
  logic [C-1:0]         a_ax, a_ay;

  logic a_en, b_en;

  // stage A: absolute axis distances
  logic [C:0] dxw, dyw, dxn, dyn;
  logic [C-1:0] ax, ay;

  always_comb begin
    dxw = {in_ex[C-1], in_ex} - {in_sx[C-1], in_sx};
    dyw = {in_ey[C-1], in_ey} - {in_sy[C-1], in_sy};
    dxn = {(C+1){1'b0}} - dxw;
    dyn = {(C+1){1'b0}} - dyw;
    ax  = dxw[C] ? dxn[C-1:0] : dxw[C-1:0];
    ay  = dyw[C] ? dyn[C-1:0] : dyw[C-1:0];
  end

  // a stage moves when it is empty or its successor moves
  assign b_en     = !out_valid || out_ready;
  assign a_en     = !a_valid || b_en;
  assign in_ready = a_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_cmd   <= in_cmd;
      a_style <= in_style;
      a_sx    <= in_sx;
      a_sy    <= in_sy;
      a_ex    <= in_ex;
      a_ey    <= in_ey;
      a_tx    <= in_tx;
      a_ty    <= in_ty;
      a_ax    <= ax;
      a_ay    <= ay;
    end
  end

  // stage B: diagonal leg length and bend points
  logic [C-1:0] len;
  logic [C:0]   lenw, sxw, syw, exw, eyw, d1x, d1y, d3x, d3y;

  always_comb begin
    len  = (a_ax < a_ay) ? a_ax : a_ay;
    lenw = {1'b0, len};
    sxw  = {a_sx[C-1], a_sx};
    syw  = {a_sy[C-1], a_sy};
    exw  = {a_ex[C-1], a_ex};
    eyw  = {a_ey[C-1], a_ey};
    // leg from start, signed toward end
    d1x  = (a_ex < a_sx) ? sxw - lenw : sxw + lenw;
    d1y  = (a_ey < a_sy) ? syw - lenw : syw + lenw;
    // leg from end, signed toward start
    d3x  = (a_sx < a_ex) ? exw - lenw : exw + lenw;
    d3y  = (a_sy < a_ey) ? eyw - lenw : eyw + lenw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_en) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      out_cmd   <= a_cmd;
      out_style <= a_style;
      out_tx    <= a_tx;
      out_ty    <= a_ty;
      out_cx[STYLE_CORNER_A]   <= a_sx;
      out_cy[STYLE_CORNER_A]   <= a_ey;
      out_cx[STYLE_DIAG_START] <= d1x[C-1:0];
      out_cy[STYLE_DIAG_START] <= d1y[C-1:0];
      out_cx[STYLE_CORNER_B]   <= a_ex;
      out_cy[STYLE_CORNER_B]   <= a_sy;
      out_cx[STYLE_DIAG_END]   <= d3x[C-1:0];
      out_cy[STYLE_DIAG_END]   <= d3y[C-1:0];
    end
  end

endmodule

>>> rtl/core/wes_dist.sv
// Three stages: distance to target per axis, squares, squared distance.
module wes_dist import wes_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  cmd_t                                  in_cmd,
  input  style_t                                in_style,
  input  logic signed [COORD_BITS-1:0]          in_tx,
  input  logic signed [COORD_BITS-1:0]          in_ty,
  input  logic [NUM_STYLES-1:0][COORD_BITS-1:0] in_cx,
  input  logic [NUM_STYLES-1:0][COORD_BITS-1:0] in_cy,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output cmd_t                                  out_cmd,
  output style_t                                out_style,
  output logic [NUM_STYLES-1:0][COORD_BITS-1:0] out_cx,
  output logic [NUM_STYLES-1:0][COORD_BITS-1:0] out_cy,
  output logic [NUM_STYLES-1:0][2*COORD_BITS:0] out_dist
);

  localparam int C = COORD_BITS;

  // stage C: per-axis distance
  logic                                c_valid;
  cmd_t                                c_cmd;
  style_t                              c_style;
  logic [NUM_STYLES-1:0][C-1:0]        c_cx, c_cy, c_dx, c_dy;
  // stage D: squares
  logic                                d_valid;
  cmd_t                                d_cmd;
  style_t                              d_style;
  logic [NUM_STYLES-1:0][C-1:0]        d_cx, d_cy;
  logic [NUM_STYLES-1:0][2*C-1:0]      d_sqx, d_sqy;

  logic c_en, d_en, e_en;

  assign e_en     = !out_valid || out_ready;
  assign d_en     = !d_valid || e_en;
  assign c_en     = !c_valid || d_en;
  assign in_ready = c_en;

  // absolute difference to target, each candidate independent
  logic [NUM_STYLES-1:0][C:0]   dxw, dyw, dxn, dyn;
  logic [NUM_STYLES-1:0][C-1:0] dx, dy;

  always_comb begin
    for (int i = 0; i < NUM_STYLES; i++) begin
      dxw[i] = {in_cx[i][C-1], in_cx[i]} - {in_tx[C-1], in_tx};
      dyw[i] = {in_cy[i][C-1], in_cy[i]} - {in_ty[C-1], in_ty};
      dxn[i] = {(C+1){1'b0}} - dxw[i];
      dyn[i] = {(C+1){1'b0}} - dyw[i];
      dx[i]  = dxw[i][C] ? dxn[i][C-1:0] : dxw[i][C-1:0];
      dy[i]  = dyw[i][C] ? dyn[i][C-1:0] : dyw[i][C-1:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (c_en) begin
        c_valid <= in_valid;
      end
      if (d_en) begin
        d_valid <= c_valid;
      end
      if (e_en) begin
        out_valid <= d_valid;
      end
    end
  end

  // stage C
  always_ff @(posedge clk) begin
    if (c_en) begin
      c_cmd   <= in_cmd;
      c_style <= in_style;
      c_cx    <= in_cx;
      c_cy    <= in_cy;
      c_dx    <= dx;
      c_dy    <= dy;
    end
  end

  // stage D: one multiplier per axis and candidate
  always_ff @(posedge clk) begin
    if (d_en) begin
      d_cmd   <= c_cmd;
      d_style <= c_style;
      d_cx    <= c_cx;
      d_cy    <= c_cy;
      for (int i = 0; i < NUM_STYLES; i++) begin
        d_sqx[i] <= {{C{1'b0}}, c_dx[i]} * {{C{1'b0}}, c_dx[i]};
        d_sqy[i] <= {{C{1'b0}}, c_dy[i]} * {{C{1'b0}}, c_dy[i]};
      end
    end
  end

  // stage E: sum of squares, one bit wider
  always_ff @(posedge clk) begin
    if (e_en) begin
      out_cmd   <= d_cmd;
      out_style <= d_style;
      out_cx    <= d_cx;
      out_cy    <= d_cy;
      for (int i = 0; i < NUM_STYLES; i++) begin
        out_dist[i] <= {1'b0, d_sqx[i]} + {1'b0, d_sqy[i]};
      end
    end
  end

endmodule

>>> rtl/core/wes_pick.sv
// Two stages: pairwise minimum, then final choice into the output register.
module wes_pick import wes_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  cmd_t                                  in_cmd,
  input  style_t                                in_style,
  input  logic [NUM_STYLES-1:0][COORD_BITS-1:0] in_cx,
  input  logic [NUM_STYLES-1:0][COORD_BITS-1:0] in_cy,
  input  logic [NUM_STYLES-1:0][2*COORD_BITS:0] in_dist,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [COORD_BITS-1:0]                 out_bx,
  output logic [COORD_BITS-1:0]                 out_by,
  output style_t                                out_style
);

  localparam int C = COORD_BITS;

  // stage F registers
  logic                         f_valid;
  cmd_t                         f_cmd;
  style_t                       f_style;
  logic [NUM_STYLES-1:0][C-1:0] f_cx, f_cy;
  logic [2*C:0]                 f_d01, f_d23;
  style_t                       f_w01, f_w23;

  logic f_en, g_en;

  assign g_en     = !out_valid || out_ready;
  assign f_en     = !f_valid || g_en;
  assign in_ready = f_en;

  // pair winners; the lower style keeps a tie
  logic in_lt01, in_lt23;
  assign in_lt01 = in_dist[STYLE_DIAG_START] < in_dist[STYLE_CORNER_A];
  assign in_lt23 = in_dist[STYLE_DIAG_END] < in_dist[STYLE_CORNER_B];

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (f_en) begin
        f_valid <= in_valid;
      end
      if (g_en) begin
        out_valid <= f_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (f_en) begin
      f_cmd   <= in_cmd;
      f_style <= in_style;
      f_cx    <= in_cx;
      f_cy    <= in_cy;
      f_d01   <= in_lt01 ? in_dist[STYLE_DIAG_START] : in_dist[STYLE_CORNER_A];
      f_w01   <= in_lt01 ? STYLE_DIAG_START : STYLE_CORNER_A;
      f_d23   <= in_lt23 ? in_dist[STYLE_DIAG_END] : in_dist[STYLE_CORNER_B];
      f_w23   <= in_lt23 ? STYLE_DIAG_END : STYLE_CORNER_B;
    end
  end

  // final choice: given style, or nearest of the two pair winners
  style_t sel;

  always_comb begin
    case (f_cmd)
      CMD_PLACE: sel = f_style;
      CMD_SNAP:  sel = (f_d23 < f_d01) ? f_w23 : f_w01;
      default:   sel = f_style;
    endcase
  end

  always_ff @(posedge clk) begin
    if (g_en) begin
      out_bx    <= f_cx[sel];
      out_by    <= f_cy[sel];
      out_style <= sel;
    end
  end

endmodule

>>> rtl/core/wire_elbow_snap_top.sv
// Wire elbow snap: bend point of a two-segment wire route.
// Input stream (s_*): one request per transfer; s_tuser carries cmd
// (place for the given style, or snap to the style nearest the target),
// s_tdata the start, end, style and target coordinates.
// Output stream (m_*): one result per request, in request order, with the
// bend point and the style used.
// Pipeline depth: 2 stages candidate points, 3 stages squared distance,
// 2 stages selection and output register.
// Throughput: one request per cycle while the output is not stalled; each
// stage holds its own valid bit, so empty stages fill even while the output is stalled.
// When m_tready is low the result holds in the output register and the
// stages behind it fill up; s_tready drops only once every stage is full.
// Reset clears all valid bits; no request is in flight after reset.
`include "wire_elbow_snap_top_assert.svh"
module wire_elbow_snap_top import wes_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // cmd
  input  logic [0:0] s_tuser,
  // start_x, start_y, end_x, end_y, style_in, target_x, target_y, zero pad
  input  logic [((6*COORD_BITS+2+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // bend_x, bend_y, style_out, zero pad
  output logic [((2*COORD_BITS+2+7)/8)*8-1:0] m_tdata
);

  localparam int C     = COORD_BITS;
  localparam int OUT_W = ((2*COORD_BITS+2+7)/8)*8;

  // unpack the request
  cmd_t                 in_cmd;
  style_t               in_style;
  logic signed [C-1:0]  in_sx, in_sy, in_ex, in_ey, in_tx, in_ty;

  assign in_cmd   = cmd_t'(s_tuser[0]);
  assign in_sx    = s_tdata[C-1:0];
  assign in_sy    = s_tdata[2*C-1:C];
  assign in_ex    = s_tdata[3*C-1:2*C];
  assign in_ey    = s_tdata[4*C-1:3*C];
  assign in_style = style_t'(s_tdata[4*C+1:4*C]);
  assign in_tx    = s_tdata[5*C+1:4*C+2];
  assign in_ty    = s_tdata[6*C+1:5*C+2];

  // candidate points
  logic                         cand_valid, cand_ready;
  cmd_t                         cand_cmd;
  style_t                       cand_style;
  logic signed [C-1:0]          cand_tx, cand_ty;
  logic [NUM_STYLES-1:0][C-1:0] cand_cx, cand_cy;

  wes_cand #(.COORD_BITS(C)) u_cand (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (in_cmd),
    .in_style  (in_style),
    .in_sx     (in_sx),
    .in_sy     (in_sy),
    .in_ex     (in_ex),
    .in_ey     (in_ey),
    .in_tx     (in_tx),
    .in_ty     (in_ty),
    .out_valid (cand_valid),
    .out_ready (cand_ready),
    .out_cmd   (cand_cmd),
    .out_style (cand_style),
    .out_tx    (cand_tx),
    .out_ty    (cand_ty),
    .out_cx    (cand_cx),
    .out_cy    (cand_cy)
  );

  // squared distances to target
  logic                           dist_valid, dist_ready;
  cmd_t                           dist_cmd;
  style_t                         dist_style;
  logic [NUM_STYLES-1:0][C-1:0]   dist_cx, dist_cy;
  logic [NUM_STYLES-1:0][2*C:0]   dist_d;

  wes_dist #(.COORD_BITS(C)) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cand_valid),
    .in_ready  (cand_ready),
    .in_cmd    (cand_cmd),
    .in_style  (cand_style),
    .in_tx     (cand_tx),
    .in_ty     (cand_ty),
    .in_cx     (cand_cx),
    .in_cy     (cand_cy),
    .out_valid (dist_valid),
    .out_ready (dist_ready),
    .out_cmd   (dist_cmd),
    .out_style (dist_style),
    .out_cx    (dist_cx),
    .out_cy    (dist_cy),
    .out_dist  (dist_d)
  );

  // selection and output register
  logic [C-1:0] out_bx, out_by;
  style_t       out_style;

  wes_pick #(.COORD_BITS(C)) u_pick (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dist_valid),
    .in_ready  (dist_ready),
    .in_cmd    (dist_cmd),
    .in_style  (dist_style),
    .in_cx     (dist_cx),
    .in_cy     (dist_cy),
    .in_dist   (dist_d),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_bx    (out_bx),
    .out_by    (out_by),
    .out_style (out_style)
  );

  // pack the result, zero fill to whole bytes
  assign m_tdata = OUT_W'({out_style, out_by, out_bx});

  // checks
  `WES_ASSERT_RST(a_rst_clears_out, rst |=> !m_tvalid)
  `WES_ASSERT(a_cand_holds, cand_valid && !cand_ready |=> cand_valid && $stable(cand_cx))
  `WES_ASSERT(a_dist_holds, dist_valid && !dist_ready |=> dist_valid && $stable(dist_d))

endmodule
